@@ design/point_in_quad_crossing_test_assert.svh @@
// Assertion macros for the quad crossing test.
`ifndef POINT_IN_QUAD_CROSSING_TEST_ASSERT_SVH
`define POINT_IN_QUAD_CROSSING_TEST_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PIC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PIC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/pic_pkg.sv @@
`timescale 1ns / 1ps

package pic_pkg;

    localparam int COORD_FRAC_BITS = 8;
    localparam int VERTEX_W        = 24;
    localparam int PIXEL_W         = 12;
    localparam int SCALED_W        = PIXEL_W + COORD_FRAC_BITS;
    localparam int WIDE_W          = (VERTEX_W > SCALED_W) ? VERTEX_W : SCALED_W;
    localparam int DIFF_W          = WIDE_W + 1;
    localparam int PROD_W          = 2 * DIFF_W;
    localparam int SUM_W           = PROD_W + 1;
    localparam int NUM_EDGES       = 4;
    localparam int COUNT_W         = 3;
    localparam int CFG_INDEX_W     = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_A_X = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_A_Y = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_B_X = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_B_Y = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_C_X = CFG_INDEX_W'(4);
    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_C_Y = CFG_INDEX_W'(5);
    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_D_X = CFG_INDEX_W'(6);
    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_D_Y = CFG_INDEX_W'(7);

    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef struct packed {
        logic signed [VERTEX_W-1:0] x;
        logic signed [VERTEX_W-1:0] y;
    } vertex_t;

    typedef struct packed {
        logic signed [PIXEL_W-1:0] pixel_x;
        logic signed [PIXEL_W-1:0] pixel_y;
    } pixel_t;

    typedef struct packed {
        logic               inside_res;
        logic [COUNT_W-1:0] crossing_count;
    } result_t;

    // Load enables of the edge pipeline stages, one field per stage.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

endpackage

@@ design/pic_edge.sv @@
`timescale 1ns / 1ps

module pic_edge (
    input  logic               clk,
    input  pic_pkg::stage_en_t en,
    input  pic_pkg::vertex_t   v0,
    input  pic_pkg::vertex_t   v1,
    input  pic_pkg::pixel_t    pixel,
    output logic               crossed
);

    // stage 1: order the edge ends by y, scale the pixel
    pic_pkg::wide_t lo_x_reg, lo_y_reg, hi_x_reg, hi_y_reg, px_reg, py_reg;
    pic_pkg::wide_t lo_x_next, lo_y_next, hi_x_next, hi_y_next, px_next, py_next;
    // stage 2: differences and span test
    pic_pkg::diff_t a_reg, dy_reg, b_reg, dx_reg;
    pic_pkg::diff_t a_next, dy_next, b_next, dx_next;
    logic           span2_reg, span2_next;
    // stage 3: products
    pic_pkg::prod_t p1_reg, p2_reg, p1_next, p2_next;
    logic           span3_reg;
    // stage 4: sign of the sum
    pic_pkg::sum_t  sum;
    logic           cross_reg, cross_next;

    always_comb
    begin
        if (v0.y < v1.y)
        begin
            lo_x_next = pic_pkg::wide_t'(v0.x);
            lo_y_next = pic_pkg::wide_t'(v0.y);
            hi_x_next = pic_pkg::wide_t'(v1.x);
            hi_y_next = pic_pkg::wide_t'(v1.y);
        end
        else
        begin
            lo_x_next = pic_pkg::wide_t'(v1.x);
            lo_y_next = pic_pkg::wide_t'(v1.y);
            hi_x_next = pic_pkg::wide_t'(v0.x);
            hi_y_next = pic_pkg::wide_t'(v0.y);
        end
        px_next = pic_pkg::wide_t'(pixel.pixel_x) <<< pic_pkg::COORD_FRAC_BITS;
        py_next = pic_pkg::wide_t'(pixel.pixel_y) <<< pic_pkg::COORD_FRAC_BITS;
    end

    always_comb
    begin
        a_next     = pic_pkg::diff_t'(lo_x_reg) - pic_pkg::diff_t'(px_reg);
        dy_next    = pic_pkg::diff_t'(hi_y_reg) - pic_pkg::diff_t'(lo_y_reg);
        b_next     = pic_pkg::diff_t'(py_reg) - pic_pkg::diff_t'(lo_y_reg);
        dx_next    = pic_pkg::diff_t'(hi_x_reg) - pic_pkg::diff_t'(lo_x_reg);
        // half-open span, empty for a horizontal edge
        span2_next = (lo_y_reg <= py_reg) && (py_reg < hi_y_reg);
    end

    always_comb
    begin
        p1_next = a_reg * dy_reg;
        p2_next = b_reg * dx_reg;
    end

    always_comb
    begin
        sum        = pic_pkg::sum_t'(p1_reg) + pic_pkg::sum_t'(p2_reg);
        cross_next = span3_reg && !sum[pic_pkg::SUM_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            lo_x_reg <= lo_x_next;
            lo_y_reg <= lo_y_next;
            hi_x_reg <= hi_x_next;
            hi_y_reg <= hi_y_next;
            px_reg   <= px_next;
            py_reg   <= py_next;
        end
        if (en.s2)
        begin
            a_reg     <= a_next;
            dy_reg    <= dy_next;
            b_reg     <= b_next;
            dx_reg    <= dx_next;
            span2_reg <= span2_next;
        end
        if (en.s3)
        begin
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            span3_reg <= span2_reg;
        end
        if (en.s4)
        begin
            cross_reg <= cross_next;
        end
    end

    assign crossed = cross_reg;

endmodule

@@ design/point_in_quad_crossing_test.sv @@
`timescale 1ns / 1ps
// channel   valid         flow ctl       payload
// pixel     pixel_valid   pixel_stall    pixel   (pixel_x, pixel_y)
// result    result_valid  result_stall   result  (inside_res, crossing_count)
// cfg       cfg_valid     cfg_ready      cfg_index, cfg_data
//
// One request per cycle while result_stall is low; stages are order,
// subtract, multiply, sum/sign and count/output register.
// Each stage loads when empty or when the next stage moves, so bubbles close
// up under result_stall. pixel_stall rises only when all five stages are full.
// Reset clears the vertex registers and all valid bits; cfg_ready is always 1.

module point_in_quad_crossing_test (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pixel_valid,
    output logic                                pixel_stall,
    input  pic_pkg::pixel_t                     pixel,
    output logic                                result_valid,
    input  logic                                result_stall,
    output pic_pkg::result_t                    result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pic_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic signed [pic_pkg::VERTEX_W-1:0] cfg_data
);

    pic_pkg::vertex_t   vertex_reg [pic_pkg::NUM_EDGES];
    pic_pkg::vertex_t   vertex_next [pic_pkg::NUM_EDGES];
    logic [pic_pkg::NUM_EDGES-1:0] stage_valid_reg, stage_valid_next;
    logic               result_valid_reg, result_valid_next;
    pic_pkg::result_t   result_reg, result_next;
    pic_pkg::stage_en_t en;
    logic               out_en;
    logic [pic_pkg::NUM_EDGES-1:0] edge_hit;

    always_comb
    begin
        for (int i = 0; i < pic_pkg::NUM_EDGES; i++)
        begin
            vertex_next[i] = vertex_reg[i];
        end
        if (cfg_valid)
        begin
            unique case (cfg_index)
                pic_pkg::REG_VERTEX_A_X: vertex_next[0].x = cfg_data;
                pic_pkg::REG_VERTEX_A_Y: vertex_next[0].y = cfg_data;
                pic_pkg::REG_VERTEX_B_X: vertex_next[1].x = cfg_data;
                pic_pkg::REG_VERTEX_B_Y: vertex_next[1].y = cfg_data;
                pic_pkg::REG_VERTEX_C_X: vertex_next[2].x = cfg_data;
                pic_pkg::REG_VERTEX_C_Y: vertex_next[2].y = cfg_data;
                pic_pkg::REG_VERTEX_D_X: vertex_next[3].x = cfg_data;
                pic_pkg::REG_VERTEX_D_Y: vertex_next[3].y = cfg_data;
                default: ;
            endcase
        end
    end

    // stage enables ripple back from the output register
    always_comb
    begin
        out_en = !result_valid_reg || !result_stall;
        en.s4  = !stage_valid_reg[3] || out_en;
        en.s3  = !stage_valid_reg[2] || en.s4;
        en.s2  = !stage_valid_reg[1] || en.s3;
        en.s1  = !stage_valid_reg[0] || en.s2;
    end

    always_comb
    begin
        stage_valid_next    = stage_valid_reg;
        if (en.s1)
            stage_valid_next[0] = pixel_valid;
        if (en.s2)
            stage_valid_next[1] = stage_valid_reg[0];
        if (en.s3)
            stage_valid_next[2] = stage_valid_reg[1];
        if (en.s4)
            stage_valid_next[3] = stage_valid_reg[2];
        result_valid_next = out_en ? stage_valid_reg[3] : result_valid_reg;
    end

    always_comb
    begin
        result_next.crossing_count = '0;
        for (int i = 0; i < pic_pkg::NUM_EDGES; i++)
        begin
            result_next.crossing_count = result_next.crossing_count
                                         + pic_pkg::COUNT_W'(edge_hit[i]);
        end
        result_next.inside_res = result_next.crossing_count[0];
    end

    for (genvar g = 0; g < pic_pkg::NUM_EDGES; g++)
    begin : g_edge
        pic_edge u_edge (
            .clk     (clk),
            .en      (en),
            .v0      (vertex_reg[g]),
            .v1      (vertex_reg[(g + 1) % pic_pkg::NUM_EDGES]),
            .pixel   (pixel),
            .crossed (edge_hit[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pic_pkg::NUM_EDGES; i++)
            begin
                vertex_reg[i] <= '0;
            end
            stage_valid_reg  <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            vertex_reg       <= vertex_next;
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en && stage_valid_reg[3])
        begin
            result_reg <= result_next;
        end
    end

    assign pixel_stall  = !en.s1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

endmodule

@@ design/pic_checker.sv @@
`timescale 1ns / 1ps
`include "point_in_quad_crossing_test_assert.svh"

module pic_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             pixel_stall,
    input logic             result_valid,
    input logic             result_stall,
    input pic_pkg::result_t result
);

    `PIC_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
        result_valid && $stable(result), "stalled result changed")

    `PIC_ASSERT_NOW(a_parity, result_valid,
        result.inside_res == result.crossing_count[0], "inside flag disagrees with count")

    `PIC_ASSERT_NOW(a_count_range, result_valid,
        result.crossing_count <= 3'd4, "crossing count above edge count")

    // input backs up only when the result side is blocked
    `PIC_ASSERT_NOW(a_stall_cause, pixel_stall,
        result_valid && result_stall, "pixel stall without a blocked result")

endmodule

bind point_in_quad_crossing_test pic_checker u_pic_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_stall  (pixel_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
